@@ rtl/psf_pkg.sv @@
// Shared types, character codes and lookup functions of the printf subset formatter.
`default_nettype none

package psf_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEC_DIGITS    = 10;
    localparam int HEX_DIGITS    = VALUE_W / 4;
    localparam int NULL_LEN      = 6;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int PTR_W         = $clog2(DEC_DIGITS);

    localparam logic [1:0] FN_FMT  = 2'd0;
    localparam logic [1:0] FN_STR  = 2'd1;
    localparam logic [1:0] FN_INT  = 2'd2;
    localparam logic [1:0] FN_NULL = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_X     = 8'h78;

    // what one result carries
    typedef enum logic [2:0] {
        SEL_CHAR  = 3'd0,
        SEL_PCT   = 3'd1,
        SEL_MINUS = 3'd2,
        SEL_NULL  = 3'd3,
        SEL_DIG   = 3'd4,
        SEL_CNT   = 3'd5,
        SEL_ERR   = 3'd6
    } t_sel;

    typedef struct packed {
        logic load_char;
        logic load_dec;
        logic load_hex;
        logic conv_step;
        logic ptr_find;
        logic ptr_null;
        logic ptr_dec;
        logic emit;
        t_sel sel;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic ptr_zero;
    } t_dp_sts;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:  c = 8'h30;
            4'd1:  c = 8'h31;
            4'd2:  c = 8'h32;
            4'd3:  c = 8'h33;
            4'd4:  c = 8'h34;
            4'd5:  c = 8'h35;
            4'd6:  c = 8'h36;
            4'd7:  c = 8'h37;
            4'd8:  c = 8'h38;
            4'd9:  c = 8'h39;
            4'd10: c = 8'h61;
            4'd11: c = 8'h62;
            4'd12: c = 8'h63;
            4'd13: c = 8'h64;
            4'd14: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

    // "(null)" read with a down-counting index: 5 gives the first character
    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd5:    c = 8'h28;
            3'd4:    c = 8'h6e;
            3'd3:    c = 8'h75;
            3'd2:    c = 8'h6c;
            3'd1:    c = 8'h6c;
            3'd0:    c = 8'h29;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/psf_ctrl.sv @@
// Controller of the printf subset formatter: format parse mode and result sequencing.
`default_nettype none

module psf_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [1:0]            i_func,
    input  wire logic [7:0]            i_char,
    input  wire logic                  i_sign,
    input  wire psf_pkg::t_dp_sts      i_sts,
    output psf_pkg::t_dp_cmd           o_cmd,
    output logic                       o_ready
);

    typedef enum logic [5:0] {
        M_IDLE   = 6'b000001,
        M_PCT    = 6'b000010,
        M_SFIRST = 6'b000100,
        M_SBODY  = 6'b001000,
        M_DEC    = 6'b010000,
        M_HEX    = 6'b100000
    } t_mode;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_ERR   = 10'b0000000010,
        ST_CHAR  = 10'b0000000100,
        ST_CNT   = 10'b0000001000,
        ST_PCT   = 10'b0000010000,
        ST_NULL  = 10'b0000100000,
        ST_CONV  = 10'b0001000000,
        ST_FIND  = 10'b0010000000,
        ST_MINUS = 10'b0100000000,
        ST_DIG   = 10'b1000000000
    } t_state;

    t_state                      r_state, n_state;
    t_state                      r_after, n_after;
    t_mode                       r_mode, n_mode;
    logic                        r_neg, n_neg;
    logic [psf_pkg::STEP_W-1:0]  r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_mode  = r_mode;
        n_neg   = r_neg;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_char = 1'b1;
                    unique case (r_mode) inside
                        M_IDLE: begin
                            if (i_func != psf_pkg::FN_FMT) begin
                                n_state = ST_ERR;
                            end else if (i_char == psf_pkg::CH_NUL) begin
                                n_state = ST_CNT;
                            end else if (i_char == psf_pkg::CH_PCT) begin
                                n_mode = M_PCT;
                            end else begin
                                n_state = ST_CHAR;
                            end
                        end
                        M_PCT: begin
                            if (i_func != psf_pkg::FN_FMT) begin
                                n_state = ST_ERR;
                            end else if (i_char == psf_pkg::CH_S) begin
                                n_mode = M_SFIRST;
                            end else if (i_char == psf_pkg::CH_D) begin
                                n_mode = M_DEC;
                            end else if (i_char == psf_pkg::CH_X) begin
                                n_mode = M_HEX;
                            end else begin
                                // emit '%'; a non-'%' byte is then plain format text
                                n_mode  = M_IDLE;
                                n_state = ST_PCT;
                                if (i_char == psf_pkg::CH_PCT) begin
                                    n_after = ST_IDLE;
                                end else if (i_char == psf_pkg::CH_NUL) begin
                                    n_after = ST_CNT;
                                end else begin
                                    n_after = ST_CHAR;
                                end
                            end
                        end
                        M_SFIRST, M_SBODY: begin
                            if (i_func == psf_pkg::FN_STR) begin
                                if (i_char == psf_pkg::CH_NUL) begin
                                    n_mode = M_IDLE;
                                end else begin
                                    n_mode  = M_SBODY;
                                    n_state = ST_CHAR;
                                end
                            end else if (i_func == psf_pkg::FN_NULL && r_mode == M_SFIRST) begin
                                n_mode         = M_IDLE;
                                n_state        = ST_NULL;
                                o_cmd.ptr_null = 1'b1;
                            end else begin
                                n_state = ST_ERR;
                            end
                        end
                        M_DEC: begin
                            if (i_func != psf_pkg::FN_INT) begin
                                n_state = ST_ERR;
                            end else begin
                                n_mode         = M_IDLE;
                                n_state        = ST_CONV;
                                n_step         = '0;
                                n_neg          = i_sign;
                                o_cmd.load_dec = 1'b1;
                            end
                        end
                        M_HEX: begin
                            if (i_func != psf_pkg::FN_INT) begin
                                n_state = ST_ERR;
                            end else begin
                                n_mode         = M_IDLE;
                                n_state        = ST_FIND;
                                n_neg          = 1'b0;
                                o_cmd.load_hex = 1'b1;
                            end
                        end
                        default: begin
                            n_mode  = M_IDLE;
                            n_state = ST_ERR;
                        end
                    endcase
                end
            end
            ST_ERR: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = psf_pkg::SEL_ERR;
                o_cmd.last = 1'b1;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHAR: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = psf_pkg::SEL_CHAR;
                o_cmd.last = 1'b1;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CNT: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = psf_pkg::SEL_CNT;
                o_cmd.last = 1'b1;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PCT: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = psf_pkg::SEL_PCT;
                o_cmd.last = (r_after == ST_IDLE);
                if (i_sts.out_free) begin
                    n_state = r_after;
                end
            end
            ST_NULL: begin
                o_cmd.emit    = 1'b1;
                o_cmd.sel     = psf_pkg::SEL_NULL;
                o_cmd.ptr_dec = 1'b1;
                o_cmd.last    = i_sts.ptr_zero;
                if (i_sts.out_free && i_sts.ptr_zero) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                n_step          = r_step + psf_pkg::STEP_W'(1);
                if (r_step == psf_pkg::STEP_W'(psf_pkg::CONV_STEPS - 1)) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                o_cmd.ptr_find = 1'b1;
                n_state        = r_neg ? ST_MINUS : ST_DIG;
            end
            ST_MINUS: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = psf_pkg::SEL_MINUS;
                if (i_sts.out_free) begin
                    n_state = ST_DIG;
                end
            end
            ST_DIG: begin
                o_cmd.emit    = 1'b1;
                o_cmd.sel     = psf_pkg::SEL_DIG;
                o_cmd.ptr_dec = 1'b1;
                o_cmd.last    = i_sts.ptr_zero;
                if (i_sts.out_free && i_sts.ptr_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= ST_IDLE;
            r_mode  <= M_IDLE;
            r_neg   <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_mode  <= n_mode;
            r_neg   <= n_neg;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ rtl/psf_datapath.sv @@
// Datapath of the printf subset formatter: digit conversion, character count, result register.
`default_nettype none

module psf_datapath #(
    parameter int COUNT_WIDTH = 31
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [7:0]                    i_char,
    input  wire logic [psf_pkg::VALUE_W-1:0]   i_value,
    input  wire psf_pkg::t_dp_cmd              i_cmd,
    output psf_pkg::t_dp_sts                   o_sts,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [7:0]                         o_out_char,
    output logic                               o_is_count,
    output logic [COUNT_WIDTH-1:0]             o_count,
    output logic                               o_error,
    output logic                               o_last
);

    logic [7:0]                      r_char;
    logic [psf_pkg::VALUE_W-1:0]     r_bin;
    logic [3:0]                      r_dig [psf_pkg::DEC_DIGITS];
    logic [psf_pkg::PTR_W-1:0]       r_ptr;
    logic [COUNT_WIDTH-1:0]          r_count;
    logic                            r_ovalid;
    logic [7:0]                      r_ochar;
    logic                            r_ois_count;
    logic [COUNT_WIDTH-1:0]          r_ocount;
    logic                            r_oerror;
    logic                            r_olast;

    logic                            out_free;
    logic                            fire;
    logic [COUNT_WIDTH-1:0]          cnt_inc;
    logic [psf_pkg::VALUE_W-1:0]     mag;
    logic [3:0]                      conv_dig [psf_pkg::DEC_DIGITS];
    logic [psf_pkg::VALUE_W-1:0]     conv_bin;
    logic [3:0]                      hex_dig [psf_pkg::DEC_DIGITS];
    logic [psf_pkg::PTR_W-1:0]       lead;
    logic [7:0]                      n_ochar;

    assign out_free       = !r_ovalid || !i_stall;
    assign fire           = i_cmd.emit && out_free;
    assign cnt_inc        = (&r_count) ? r_count : r_count + COUNT_WIDTH'(1);
    assign mag            = i_value[psf_pkg::VALUE_W-1] ? (~i_value + psf_pkg::VALUE_W'(1))
                                                        : i_value;
    assign o_sts.out_free = out_free;
    assign o_sts.ptr_zero = (r_ptr == '0);

    // four double-dabble bit steps per cycle
    always_comb begin
        conv_dig = r_dig;
        conv_bin = r_bin;
        for (int b = 0; b < psf_pkg::BITS_PER_STEP; b++) begin
            for (int d = 0; d < psf_pkg::DEC_DIGITS; d++) begin
                if (conv_dig[d] >= 4'd5) begin
                    conv_dig[d] = conv_dig[d] + 4'd3;
                end
            end
            for (int d = psf_pkg::DEC_DIGITS - 1; d > 0; d--) begin
                conv_dig[d] = {conv_dig[d][2:0], conv_dig[d-1][3]};
            end
            conv_dig[0] = {conv_dig[0][2:0], conv_bin[psf_pkg::VALUE_W-1]};
            conv_bin    = {conv_bin[psf_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    always_comb begin
        for (int d = 0; d < psf_pkg::DEC_DIGITS; d++) begin
            hex_dig[d] = 4'd0;
        end
        for (int d = 0; d < psf_pkg::HEX_DIGITS; d++) begin
            hex_dig[d] = i_value[d*4 +: 4];
        end
    end

    // highest nonzero digit; zero prints as a single digit
    always_comb begin
        lead = '0;
        for (int d = 0; d < psf_pkg::DEC_DIGITS; d++) begin
            if (r_dig[d] != 4'd0) begin
                lead = psf_pkg::PTR_W'(d);
            end
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            psf_pkg::SEL_CHAR:  n_ochar = r_char;
            psf_pkg::SEL_PCT:   n_ochar = psf_pkg::CH_PCT;
            psf_pkg::SEL_MINUS: n_ochar = psf_pkg::CH_MINUS;
            psf_pkg::SEL_NULL:  n_ochar = psf_pkg::null_char(r_ptr[2:0]);
            psf_pkg::SEL_DIG:   n_ochar = psf_pkg::digit_char(r_dig[r_ptr]);
            default:            n_ochar = psf_pkg::CH_NUL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_count  <= '0;
        end else begin
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (fire) begin
                if (i_cmd.sel == psf_pkg::SEL_CNT) begin
                    r_count <= '0;
                end else if (i_cmd.sel != psf_pkg::SEL_ERR) begin
                    r_count <= cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ochar     <= n_ochar;
            r_ois_count <= (i_cmd.sel == psf_pkg::SEL_CNT);
            r_oerror    <= (i_cmd.sel == psf_pkg::SEL_ERR);
            r_olast     <= i_cmd.last;
            r_ocount    <= (i_cmd.sel == psf_pkg::SEL_CNT || i_cmd.sel == psf_pkg::SEL_ERR)
                           ? r_count : cnt_inc;
        end
        if (i_cmd.load_char) begin
            r_char <= i_char;
        end
        if (i_cmd.load_dec) begin
            r_bin <= mag;
            for (int d = 0; d < psf_pkg::DEC_DIGITS; d++) begin
                r_dig[d] <= 4'd0;
            end
        end else if (i_cmd.load_hex) begin
            r_dig <= hex_dig;
        end else if (i_cmd.conv_step) begin
            r_bin <= conv_bin;
            r_dig <= conv_dig;
        end
        if (i_cmd.ptr_null) begin
            r_ptr <= psf_pkg::PTR_W'(psf_pkg::NULL_LEN - 1);
        end else if (i_cmd.ptr_find) begin
            r_ptr <= lead;
        end else if (i_cmd.ptr_dec && fire && r_ptr != '0) begin
            r_ptr <= r_ptr - psf_pkg::PTR_W'(1);
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_char = r_ochar;
    assign o_is_count = r_ois_count;
    assign o_count    = r_ocount;
    assign o_error    = r_oerror;
    assign o_last     = r_olast;

endmodule

`default_nettype wire

@@ rtl/printf_subset_formatter.sv @@
// Top level of the printf subset formatter: controller and datapath.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_func, i_char, i_value
//  result    out        o_valid / i_stall    o_out_char, o_is_count, o_count, o_error, o_last
//
// One item at a time: accept, then one result per cycle while the output is free.
// Plain characters, counts and errors each give one result; "(null)" gives six.
// %d runs through the 4-bit-per-cycle BCD converter, then the leading digit is found,
// then the characters come out. %x skips the converter.
// Synchronous active-low reset clears the parse mode and the character count.
// A stalled result holds the sequencer; input stall stays high until the item is done.
`default_nettype none

module printf_subset_formatter #(
    parameter int COUNT_WIDTH = 31
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_func,
    input  wire logic [7:0]                    i_char,
    input  wire logic [psf_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [7:0]                         o_out_char,
    output logic                               o_is_count,
    output logic [COUNT_WIDTH-1:0]             o_count,
    output logic                               o_error,
    output logic                               o_last
);

    psf_pkg::t_dp_cmd cmd;
    psf_pkg::t_dp_sts sts;
    logic             ready;

    assign o_stall = !ready;

    psf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_char  (i_char),
        .i_sign  (i_value[psf_pkg::VALUE_W-1]),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (ready)
    );

    psf_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (i_char),
        .i_value    (i_value),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_is_count (o_is_count),
        .o_count    (o_count),
        .o_error    (o_error),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

@@ sim/printf_subset_formatter_checker.sv @@
`timescale 1ns / 100ps
// Checker of the printf subset formatter: predicts the results of each item and compares.
module printf_subset_formatter_checker #(
    parameter int COUNT_WIDTH = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_func,
    input  logic [7:0]                   i_char,
    input  logic [psf_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [7:0]                   i_out_char,
    input  logic                         i_is_count,
    input  logic [COUNT_WIDTH-1:0]       i_count,
    input  logic                         i_error,
    input  logic                         i_last,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);

    localparam int MAX_REPORTS = 40;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [47:0] NULL_TEXT = "(null)";

    typedef enum logic [5:0] {
        PM_IDLE      = 6'b000001,
        PM_PCT       = 6'b000010,
        PM_STR_FIRST = 6'b000100,
        PM_STR_BODY  = 6'b001000,
        PM_DEC       = 6'b010000,
        PM_HEX       = 6'b100000
    } t_parse_mode;

    typedef struct packed {
        logic [7:0]             ch;
        logic                   is_count;
        logic [COUNT_WIDTH-1:0] count;
        logic                   error;
        logic                   last;
    } t_out_item;

    t_parse_mode            parse_state = PM_IDLE;
    logic [COUNT_WIDTH-1:0] char_total = '0;
    t_out_item              pending_chars[$];
    int                     fail_count = 0;
    int                     checked = 0;
    t_out_item              want;
    t_out_item              got;

    task automatic put_char(input logic [7:0] c);
        t_out_item r;
        if (char_total != COUNT_MAX) begin
            char_total = char_total + 1'b1;
        end
        r = '0;
        r.ch = c;
        r.count = char_total;
        pending_chars.push_back(r);
    endtask

    task automatic put_error();
        t_out_item r;
        r = '0;
        r.count = char_total;
        r.error = 1'b1;
        pending_chars.push_back(r);
    endtask

    // digits come out least significant first: stack them, then emit
    task automatic put_number(input logic [31:0] v, input logic hex);
        logic [7:0]  digits[$];
        logic [31:0] rest;
        logic [31:0] dv;
        rest = v;
        do begin
            dv = hex ? (rest & 32'hF) : (rest % 32'd10);
            digits.push_front((dv < 10) ? 8'h30 + dv[7:0] : 8'h57 + dv[7:0]);
            rest = hex ? (rest >> 4) : (rest / 32'd10);
        end while (rest != 0);
        foreach (digits[k]) begin
            put_char(digits[k]);
        end
    endtask

    task automatic plain_fmt_byte(input logic [7:0] c);
        t_out_item r;
        if (c == psf_pkg::CH_NUL) begin
            r = '0;
            r.is_count = 1'b1;
            r.count = char_total;
            pending_chars.push_back(r);
            char_total = '0;
        end else if (c == psf_pkg::CH_PCT) begin
            parse_state = PM_PCT;
        end else begin
            put_char(c);
        end
    endtask

    task automatic format_item(input logic [1:0] fn, input logic [7:0] c,
                               input logic [31:0] v);
        int        first;
        t_out_item r;
        first = pending_chars.size();
        case (parse_state) inside
            PM_IDLE: begin
                if (fn != psf_pkg::FN_FMT) put_error();
                else plain_fmt_byte(c);
            end
            PM_PCT: begin
                if (fn != psf_pkg::FN_FMT) begin
                    put_error();
                end else if (c == psf_pkg::CH_PCT) begin
                    put_char(psf_pkg::CH_PCT);
                    parse_state = PM_IDLE;
                end else if (c == psf_pkg::CH_S) begin
                    parse_state = PM_STR_FIRST;
                end else if (c == psf_pkg::CH_D) begin
                    parse_state = PM_DEC;
                end else if (c == psf_pkg::CH_X) begin
                    parse_state = PM_HEX;
                end else begin
                    // unknown conversion: print the percent, then treat the byte as text
                    put_char(psf_pkg::CH_PCT);
                    parse_state = PM_IDLE;
                    plain_fmt_byte(c);
                end
            end
            PM_STR_FIRST, PM_STR_BODY: begin
                if (fn == psf_pkg::FN_STR) begin
                    if (c == psf_pkg::CH_NUL) begin
                        parse_state = PM_IDLE;
                    end else begin
                        put_char(c);
                        parse_state = PM_STR_BODY;
                    end
                end else if (fn == psf_pkg::FN_NULL && parse_state == PM_STR_FIRST) begin
                    for (int k = 0; k < 6; k++) begin
                        put_char(NULL_TEXT[47 - 8*k -: 8]);
                    end
                    parse_state = PM_IDLE;
                end else begin
                    put_error();
                end
            end
            PM_DEC: begin
                if (fn != psf_pkg::FN_INT) begin
                    put_error();
                end else begin
                    // magnitude of the most negative value still fits as unsigned
                    if (v[31]) begin
                        put_char(psf_pkg::CH_MINUS);
                        put_number(~v + 32'd1, 1'b0);
                    end else begin
                        put_number(v, 1'b0);
                    end
                    parse_state = PM_IDLE;
                end
            end
            PM_HEX: begin
                if (fn != psf_pkg::FN_INT) begin
                    put_error();
                end else begin
                    put_number(v, 1'b1);
                    parse_state = PM_IDLE;
                end
            end
            default: begin
                parse_state = PM_IDLE;
                put_error();
            end
        endcase
        if (pending_chars.size() > first) begin
            r = pending_chars.pop_back();
            r.last = 1'b1;
            pending_chars.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state = PM_IDLE;
            char_total = '0;
            pending_chars.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                format_item(i_func, i_char, i_value);
            end
            if (i_out_valid && !i_out_stall) begin
                got.ch = i_out_char;
                got.is_count = i_is_count;
                got.count = i_count;
                got.error = i_error;
                got.last = i_last;
                if (pending_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result: char=%02h is_count=%b count=%0d",
                                 $time, got.ch, got.is_count, got.count);
                        $display("%0t:                    error=%b last=%b",
                                 $time, got.error, got.last);
                    end
                end else begin
                    want = pending_chars.pop_front();
                    checked++;
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: result mismatch: expected char=%02h is_count=%b %s",
                                     $time, want.ch, want.is_count, "");
                            $display("%0t:   expected count=%0d error=%b last=%b",
                                     $time, want.count, want.error, want.last);
                            $display("%0t:   actual   char=%02h is_count=%b count=%0d",
                                     $time, got.ch, got.is_count, got.count);
                            $display("%0t:   actual   error=%b last=%b",
                                     $time, got.error, got.last);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending <= pending_chars.size();
        o_checked <= checked;
    end

endmodule

@@ sim/printf_subset_formatter_tb.sv @@
`timescale 1ns / 100ps
// Testbench top of the printf subset formatter: clock, reset, format string stimulus and verdict.
module printf_subset_formatter_tb;

    localparam int COUNT_WIDTH  = 31;
    localparam int RANDOM_ITEMS = 86;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 30;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            i_stall = 1'b0;
    logic [1:0]                      i_func = psf_pkg::FN_FMT;
    logic [7:0]                      i_char = psf_pkg::CH_NUL;
    logic [psf_pkg::VALUE_W-1:0]     i_value = '0;
    logic                            o_stall;
    logic                            o_valid;
    logic [7:0]                      o_out_char;
    logic                            o_is_count;
    logic [COUNT_WIDTH-1:0]          o_count;
    logic                            o_error;
    logic                            o_last;

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct = 36;
    int rx_stall_pct = 59;
    int items_sent = 0;
    int idle_cycles = 0;
    int directed_items;

    printf_subset_formatter #(.COUNT_WIDTH(COUNT_WIDTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_char     (i_char),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char),
        .o_is_count (o_is_count),
        .o_count    (o_count),
        .o_error    (o_error),
        .o_last     (o_last)
    );

    printf_subset_formatter_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_func       (i_func),
        .i_char       (i_char),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_char   (o_out_char),
        .i_is_count   (o_is_count),
        .i_count      (o_count),
        .i_error      (o_error),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hold the item until it is taken, with random idle cycles in front
    task automatic send_item(input logic [1:0] fn, input logic [7:0] c,
                             input logic [psf_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_char <= c;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_fmt(input logic [7:0] c);
        send_item(psf_pkg::FN_FMT, c, $urandom);
    endtask

    task automatic send_str(input logic [7:0] c);
        send_item(psf_pkg::FN_STR, c, $urandom);
    endtask

    task automatic send_int(input logic [psf_pkg::VALUE_W-1:0] v);
        send_item(psf_pkg::FN_INT, 8'($urandom_range(255)), v);
    endtask

    task automatic send_null();
        send_item(psf_pkg::FN_NULL, 8'($urandom_range(255)), $urandom);
    endtask

    // stop sending and let every pending character come out
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [psf_pkg::VALUE_W-1:0] rand_value();
        logic [psf_pkg::VALUE_W-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(99);
            1: v = 32'h8000_0000;
            2: v = 32'hFFFF_FFFF - $urandom_range(99);
            3: v = 32'h7FFF_FFFF;
            4: v = $urandom >> $urandom_range(31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // one piece of a format string: mostly well formed, some noise
    task automatic send_random_segment();
        int         kind;
        int         len;
        logic [7:0] c;
        kind = $urandom_range(99);
        if (kind < 20) begin
            c = 8'($urandom_range(1, 255));
            if (c == psf_pkg::CH_PCT) c = 8'h41;
            send_fmt(c);
        end else if (kind < 27) begin
            send_fmt(psf_pkg::CH_PCT);
            send_fmt(psf_pkg::CH_PCT);
        end else if (kind < 42) begin
            send_fmt(psf_pkg::CH_PCT);
            send_fmt(psf_pkg::CH_S);
            if ($urandom_range(4) == 0) begin
                send_null();
            end else begin
                len = $urandom_range(4);
                repeat (len) send_str(8'($urandom_range(1, 255)));
                send_str(psf_pkg::CH_NUL);
            end
        end else if (kind < 57) begin
            send_fmt(psf_pkg::CH_PCT);
            send_fmt(psf_pkg::CH_D);
            send_int(rand_value());
        end else if (kind < 70) begin
            send_fmt(psf_pkg::CH_PCT);
            send_fmt(psf_pkg::CH_X);
            send_int(rand_value());
        end else if (kind < 76) begin
            c = 8'($urandom_range(255));
            if (c == psf_pkg::CH_PCT || c == psf_pkg::CH_S || c == psf_pkg::CH_D ||
                c == psf_pkg::CH_X) c = psf_pkg::CH_NUL;
            send_fmt(psf_pkg::CH_PCT);
            send_fmt(c);
        end else if (kind < 88) begin
            send_fmt(psf_pkg::CH_NUL);
        end else begin
            send_item(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edge cases first
        send_fmt(8'hFF);
        send_int(32'hFFFF_FFFF);
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_S);
        send_str(8'hFF);
        send_null();
        send_str(psf_pkg::CH_NUL);
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_S);
        send_null();
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_S);
        send_str(psf_pkg::CH_NUL);
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_D);
        send_int(32'h8000_0000);
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_X);
        send_fmt(8'h61);
        send_int(32'hFFFF_FFFF);
        send_fmt(psf_pkg::CH_PCT);
        send_fmt(psf_pkg::CH_NUL);
        drain_results();
        directed_items = items_sent;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 36;
                    rx_stall_pct = 59;
                end
                1: begin
                    tx_idle_pct = 59;
                    rx_stall_pct = 36;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            while (items_sent < directed_items + (phase + 1) * RANDOM_ITEMS / 3) begin
                send_random_segment();
            end
            drain_results();
        end

        $display("Sent %0d items: %0d directed edge cases, the rest random format strings",
                 items_sent, directed_items);
        $display("under three sender/receiver idle mixes; %0d results checked.", checked);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/psf_pkg.sv
rtl/psf_ctrl.sv
rtl/psf_datapath.sv
rtl/printf_subset_formatter.sv
sim/printf_subset_formatter_checker.sv
sim/printf_subset_formatter_tb.sv
